### hdl/lmsc_pkg.sv
package lmsc_pkg;

    // Command bytes on the serial side
    localparam logic [7:0] CHR_X = 8'h78;
    localparam logic [7:0] CHR_Y = 8'h79;
    localparam logic [7:0] CHR_C = 8'h63;

    // Which coordinate the next plain byte sets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_X    = 2'd1;
    localparam logic [1:0] TGT_Y    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // take the input item, read the scan row
        logic emit;      // load the result register and update scan/command state
        logic pix_rd;    // read the row that holds the pending pixel
        logic pix_wr;    // write that row back with the pixel set
        logic row_done;  // row end finished: apply a pending clear
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mode;      // captured item is a scan tick
        logic last;      // scan tick is the last bit of its row
        logic pix_ok;    // a pixel is pending and lies inside the panel
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage

### hdl/lmsc_frame.sv
module lmsc_frame #(
    parameter int ROWS  = 16,
    parameter int WIDTH = 64,
    localparam int ROW_W = $clog2(ROWS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_row,
    output logic [WIDTH-1:0] o_rd_word,
    input  logic             i_wr_en,
    input  logic [ROW_W-1:0] i_wr_row,
    input  logic [WIDTH-1:0] i_wr_word,
    input  logic             i_clr
);

    // One word per panel row, bit p is pixel p of the row
    logic [WIDTH-1:0] mem [ROWS];
    logic [WIDTH-1:0] r_rd_word;
    logic [ROWS-1:0]  r_valid;
    logic             r_rd_vld;

    // Row store: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_row] <= i_wr_word;
        end
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_row];
        end
    end

    // Row valid bits: a row never written since reset or clear reads as dark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_row];
            end
        end
    end

    assign o_rd_word = r_rd_vld ? r_rd_word : '0;

endmodule

### hdl/lmsc_dp.sv
module lmsc_dp #(
    parameter int ROWS_PER_HALF = 16,
    parameter int BYTES_PER_ROW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lmsc_pkg::t_cmd    i_cmd,
    output lmsc_pkg::t_sts    o_sts,
    input  logic              i_mode,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_is_echo,
    output logic [7:0]        o_echo_byte,
    output logic              o_upper_bit,
    output logic              o_lower_bit,
    output logic [3:0]        o_row_select,
    output logic              o_latch
);
    import lmsc_pkg::*;

    localparam int ROW_BITS = BYTES_PER_ROW * 8;
    localparam int BIT_W    = $clog2(ROW_BITS);
    localparam int ROW_W    = $clog2(ROWS_PER_HALF);

    // Captured item
    logic             r_mode;
    logic [7:0]       r_byte;
    // Scan and command state
    logic [BIT_W-1:0] r_bit_pos;
    logic [ROW_W-1:0] r_scan_row;
    logic [1:0]       r_target;
    logic [7:0]       r_x;
    logic [7:0]       r_y;
    logic             r_pix_pend;
    logic             r_clr_pend;
    // Result register
    logic             r_out_valid;
    logic             r_is_echo;
    logic [7:0]       r_echo_byte;
    logic             r_upper;
    logic             r_lower;
    logic [3:0]       r_row_sel;
    logic             r_latch;

    logic             last;
    logic             pix_upper;
    logic [7:0]       y_low;
    logic [ROW_W-1:0] pix_row;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W+3:0] row_ext;
    logic [ROW_BITS-1:0] pix_mask;
    logic [ROW_BITS-1:0] up_word;
    logic [ROW_BITS-1:0] lo_word;
    logic             clr;

    // Pixel address decode
    assign pix_upper = {1'b0, r_y} < 9'(ROWS_PER_HALF);
    assign y_low     = r_y - 8'(ROWS_PER_HALF);
    assign pix_row   = pix_upper ? r_y[ROW_W-1:0] : y_low[ROW_W-1:0];
    assign pix_mask  = ROW_BITS'(1) << r_x[BIT_W-1:0];

    assign rd_row  = i_cmd.pix_rd ? pix_row : r_scan_row;
    assign clr     = i_cmd.row_done && r_clr_pend;
    assign last    = r_bit_pos == BIT_W'(ROW_BITS - 1);
    assign row_ext = {4'b0000, r_scan_row};

    lmsc_frame #(
        .ROWS  (ROWS_PER_HALF),
        .WIDTH (ROW_BITS)
    ) u_upper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (i_cmd.capture || (i_cmd.pix_rd && pix_upper)),
        .i_rd_row  (rd_row),
        .o_rd_word (up_word),
        .i_wr_en   (i_cmd.pix_wr && pix_upper),
        .i_wr_row  (pix_row),
        .i_wr_word (up_word | pix_mask),
        .i_clr     (clr)
    );

    lmsc_frame #(
        .ROWS  (ROWS_PER_HALF),
        .WIDTH (ROW_BITS)
    ) u_lower (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (i_cmd.capture || (i_cmd.pix_rd && !pix_upper)),
        .i_rd_row  (rd_row),
        .o_rd_word (lo_word),
        .i_wr_en   (i_cmd.pix_wr && !pix_upper),
        .i_wr_row  (pix_row),
        .i_wr_word (lo_word | pix_mask),
        .i_clr     (clr)
    );

    // Status to the controller
    always_comb begin
        o_sts.mode     = r_mode;
        o_sts.last     = last;
        o_sts.pix_ok   = r_pix_pend && ({1'b0, r_x} < 9'(ROW_BITS))
                         && ({1'b0, r_y} < 9'(2 * ROWS_PER_HALF));
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    // Captured item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_byte <= i_rx_byte;
        end
        if (i_cmd.emit) begin
            r_row_sel <= row_ext[3:0];
            if (r_mode) begin
                r_is_echo   <= 1'b0;
                r_echo_byte <= 8'h00;
                r_upper     <= !up_word[r_bit_pos];
                r_lower     <= !lo_word[r_bit_pos];
                r_latch     <= last;
            end else begin
                r_is_echo   <= 1'b1;
                r_echo_byte <= r_byte;
                r_upper     <= 1'b1;
                r_lower     <= 1'b1;
                r_latch     <= 1'b0;
            end
        end
    end

    // Scan position, command decode and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bit_pos   <= '0;
            r_scan_row  <= '0;
            r_target    <= TGT_NONE;
            r_x         <= 8'h00;
            r_y         <= 8'h00;
            r_pix_pend  <= 1'b0;
            r_clr_pend  <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (clr) begin
                r_clr_pend <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_mode) begin
                    if (last) begin
                        r_bit_pos  <= '0;
                        r_pix_pend <= 1'b0;
                        if (r_scan_row == ROW_W'(ROWS_PER_HALF - 1)) begin
                            r_scan_row <= '0;
                        end else begin
                            r_scan_row <= r_scan_row + 1'b1;
                        end
                    end else begin
                        r_bit_pos <= r_bit_pos + 1'b1;
                    end
                end else if (!r_pix_pend) begin
                    // bytes are ignored while a pixel waits for the row end
                    if (r_byte == CHR_X) begin
                        r_target <= TGT_X;
                    end else if (r_byte == CHR_Y) begin
                        r_target <= TGT_Y;
                    end else if (r_byte == CHR_C) begin
                        r_clr_pend <= 1'b1;
                    end else if (r_target == TGT_X) begin
                        r_x <= r_byte;
                    end else begin
                        r_y        <= r_byte;
                        r_pix_pend <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_echo    = r_is_echo;
    assign o_echo_byte  = r_echo_byte;
    assign o_upper_bit  = r_upper;
    assign o_lower_bit  = r_lower;
    assign o_row_select = r_row_sel;
    assign o_latch      = r_latch;

endmodule

### hdl/lmsc_ctrl.sv
module lmsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output lmsc_pkg::t_cmd o_cmd,
    input  lmsc_pkg::t_sts i_sts
);
    import lmsc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EMIT  = 2'd1;
    localparam logic [1:0] S_PIXRD = 2'd2;
    localparam logic [1:0] S_PIXWR = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Input is taken only between items
    assign o_in_stall = r_state != S_IDLE;

    // Sequencing of one item
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_sts.mode && i_sts.last) begin
                        if (i_sts.pix_ok) begin
                            n_state = S_PIXRD;
                        end else begin
                            o_cmd.row_done = 1'b1;
                        end
                    end
                end
            end
            S_PIXRD: begin
                o_cmd.pix_rd = 1'b1;
                n_state      = S_PIXWR;
            end
            S_PIXWR: begin
                o_cmd.pix_wr   = 1'b1;
                o_cmd.row_done = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/led_matrix_scan_with_pixel_commands_unit.sv
// Channel  | valid        | stall        | payload
// input    | i_in_valid   | o_in_stall   | i_mode, i_rx_byte
// result   | o_out_valid  | i_out_stall  | o_is_echo, o_echo_byte, o_upper_bit,
//          |              |              | o_lower_bit, o_row_select, o_latch
//
// An echo or a scan tick is captured with the row store read, then its result is registered.
// A row end with an in-range pending pixel then reads and writes back that row through the
// store's separate read and write ports. A clear wipes the row valid bits when a row ends.
// Reset (synchronous, i_rst_n low) empties the frames, the scan position and pending commands.
// A stalled result holds the next item at the result step; input stays stalled meanwhile.
module led_matrix_scan_with_pixel_commands_unit #(
    parameter int ROWS_PER_HALF = 16,
    parameter int BYTES_PER_ROW = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_is_echo,
    output logic [7:0] o_echo_byte,
    output logic       o_upper_bit,
    output logic       o_lower_bit,
    output logic [3:0] o_row_select,
    output logic       o_latch
);
    import lmsc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lmsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    lmsc_dp #(
        .ROWS_PER_HALF (ROWS_PER_HALF),
        .BYTES_PER_ROW (BYTES_PER_ROW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_rx_byte    (i_rx_byte),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_is_echo    (o_is_echo),
        .o_echo_byte  (o_echo_byte),
        .o_upper_bit  (o_upper_bit),
        .o_lower_bit  (o_lower_bit),
        .o_row_select (o_row_select),
        .o_latch      (o_latch)
    );

endmodule

### hdl/lmsc_check.sv
module lmsc_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_mode,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_is_echo,
    input logic [7:0] o_echo_byte,
    input logic       o_upper_bit,
    input logic       o_lower_bit,
    input logic [3:0] o_row_select,
    input logic       o_latch
);

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_echo_byte)
            && $stable(o_is_echo) && $stable(o_latch) && $stable(o_row_select))
        else $error("stalled result changed");

    // One item at a time: input is stalled in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is at work");

    // An echo drives the panel lines idle
    a_echo_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_echo |-> !o_latch && o_upper_bit && o_lower_bit)
        else $error("echo result drives panel lines");

    // A scan bit carries no echo byte
    a_scan_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_echo |-> o_echo_byte == 8'h00)
        else $error("scan result carries a byte");

endmodule

bind led_matrix_scan_with_pixel_commands_unit lmsc_check u_lmsc_check (.*);
